// File: rtl/mne_pkg.sv
// Package for the MIDI note event encoder.
// Holds the note command record, byte step codes and status constants.
// No dependencies.
package mne_pkg;

  // Field widths of one input item.
  localparam int unsigned PitchW    = 7;
  localparam int unsigned LengthW   = 14;
  localparam int unsigned ChannelW  = 4;
  localparam int unsigned VelocityW = 7;

  // Largest delta time that the pending delay holds.
  localparam logic [LengthW-1:0] DelayMax = 14'h3fff;

  // Upper nibbles of the note-on and note-off status bytes.
  localparam logic [3:0] StatusNoteOn  = 4'h9;
  localparam logic [3:0] StatusNoteOff = 4'h8;

  // Continuation bit of a variable-length quantity byte.
  localparam logic VlqMore = 1'b1;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // One note as the back end needs it.
  typedef struct packed {
    logic [LengthW-1:0]   delay;
    logic [PitchW-1:0]    pitch;
    logic [LengthW-1:0]   length;
    logic [ChannelW-1:0]  channel;
    logic [VelocityW-1:0] velocity;
  } note_cmd_t;

  // Byte positions within the event stream of one note.
  typedef enum logic [3:0] {
    STEP_DLY_HI,
    STEP_DLY_LO,
    STEP_ON_STATUS,
    STEP_ON_PITCH,
    STEP_ON_VEL,
    STEP_LEN_HI,
    STEP_LEN_LO,
    STEP_OFF_STATUS,
    STEP_OFF_PITCH,
    STEP_OFF_VEL
  } step_t;

  // Queue occupancy flags seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // High byte of a two-byte quantity.
  function automatic logic [7:0] vlq_hi(input logic [LengthW-1:0] v);
    vlq_hi = {VlqMore, v[LengthW-1:7]};
  endfunction

  // Final byte of a quantity; equals the whole value when it is below 128.
  function automatic logic [7:0] vlq_lo(input logic [LengthW-1:0] v);
    vlq_lo = {1'b0, v[6:0]};
  endfunction

  // True when a quantity needs two bytes.
  function automatic logic vlq_long(input logic [LengthW-1:0] v);
    vlq_long = |v[LengthW-1:7];
  endfunction

endpackage

// File: rtl/midi_note_event_encoder.sv
// MIDI note event encoder, top level.
// Channels: the input channel (in_valid/in_ready) takes one item with
// rest, pitch, length, channel and velocity. A rest only adds its length
// to the pending delta time, saturating at 16383, and yields no bytes.
// A note yields 8 to 10 bytes on the output channel (out_valid/out_ready):
// delta time as a one- or two-byte quantity, note-on, note length as a
// one- or two-byte quantity, note-off; last marks the final byte.
// The first byte of a note is valid once the accepted item has passed the
// queue and the output register. The serializer gives one byte per cycle
// while the receiver takes each byte, so notes follow with no gap; a rest
// yields no bytes. The byte-wide output channel sets this rate.
// A command queue of QueueDepth notes lets the front keep accepting while
// the serializer works; when the receiver stalls, the byte holds and the
// queue fills, after which notes wait while rests are still taken.
// Reset (rst, synchronous) clears the pending delay, the queue and the
// output valid.
// Depends on mne_pkg, mne_front, mne_queue and mne_back.
module midi_note_event_encoder #(
  parameter int unsigned QueueDepth = mne_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           rest,
  input  logic [mne_pkg::PitchW-1:0]     pitch,
  input  logic [mne_pkg::LengthW-1:0]    length,
  input  logic [mne_pkg::ChannelW-1:0]   channel,
  input  logic [mne_pkg::VelocityW-1:0]  velocity,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           last
);

  mne_pkg::queue_status_t q_status;
  mne_pkg::note_cmd_t     push_cmd;
  mne_pkg::note_cmd_t     head;
  logic                   push;
  logic                   pop;

  // Accept and classify items.
  mne_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rest     (rest),
    .pitch    (pitch),
    .length   (length),
    .channel  (channel),
    .velocity (velocity),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue of pending notes.
  mne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Serialize notes into event bytes.
  mne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// File: rtl/mne_front.sv
// Front end of the MIDI note event encoder.
// Accepts items, folds rests into the pending delay and queues notes.
// Depends on mne_pkg.
module mne_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           rest,
  input  logic [mne_pkg::PitchW-1:0]     pitch,
  input  logic [mne_pkg::LengthW-1:0]    length,
  input  logic [mne_pkg::ChannelW-1:0]   channel,
  input  logic [mne_pkg::VelocityW-1:0]  velocity,
  input  mne_pkg::queue_status_t         q_status,
  output logic                           push,
  output mne_pkg::note_cmd_t             push_cmd
);

  logic [mne_pkg::LengthW-1:0] pending_delay;
  logic [mne_pkg::LengthW-1:0] pending_delay_next;
  logic [mne_pkg::LengthW:0]   delay_sum;
  logic                        accept;

  // A rest never needs queue space; a note waits for a free slot.
  assign in_ready = rest | ~q_status.full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & ~rest;

  // Build the queued command from the item and the pending delay.
  always_comb begin
    push_cmd.delay    = pending_delay;
    push_cmd.pitch    = pitch;
    push_cmd.length   = length;
    push_cmd.channel  = channel;
    push_cmd.velocity = velocity;
  end

  // Saturating accumulation of rests; a note clears the delay.
  always_comb begin
    delay_sum          = {1'b0, pending_delay} + {1'b0, length};
    pending_delay_next = pending_delay;
    if (accept) begin
      if (rest) begin
        if (delay_sum > {1'b0, mne_pkg::DelayMax}) begin
          pending_delay_next = mne_pkg::DelayMax;
        end else begin
          pending_delay_next = delay_sum[mne_pkg::LengthW-1:0];
        end
      end else begin
        pending_delay_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_delay <= '0;
    end else begin
      pending_delay <= pending_delay_next;
    end
  end

endmodule

// File: rtl/mne_queue.sv
// Command queue between the front and back ends of the note encoder.
// A small register FIFO of note commands. Depends on mne_pkg.
module mne_queue #(
  parameter int unsigned Depth = mne_pkg::QueueDepthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mne_pkg::note_cmd_t     push_cmd,
  input  logic                   pop,
  output mne_pkg::note_cmd_t     head,
  output mne_pkg::queue_status_t status
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mne_pkg::note_cmd_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // Storage needs no reset; the count guards every read.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/mne_back.sv
// Back end of the MIDI note event encoder.
// Serializes the queued note at the head into event bytes through an
// output register. Depends on mne_pkg.
module mne_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mne_pkg::note_cmd_t     head,
  input  mne_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   last
);

  mne_pkg::step_t step;
  mne_pkg::step_t step_next;
  logic [7:0]     byte_next;
  logic           last_next;
  logic           load;

  // Load a new byte whenever a note is queued and the output register is free or being taken.
  assign load = ~q_status.empty & (~out_valid | out_ready);
  assign pop  = load & last_next;

  // Byte for the current step; short quantities skip their high byte.
  always_comb begin
    byte_next = '0;
    last_next = 1'b0;
    step_next = step;
    case (step)
      mne_pkg::STEP_DLY_HI: begin
        if (mne_pkg::vlq_long(head.delay)) begin
          byte_next = mne_pkg::vlq_hi(head.delay);
          step_next = mne_pkg::STEP_DLY_LO;
        end else begin
          byte_next = mne_pkg::vlq_lo(head.delay);
          step_next = mne_pkg::STEP_ON_STATUS;
        end
      end
      mne_pkg::STEP_DLY_LO: begin
        byte_next = mne_pkg::vlq_lo(head.delay);
        step_next = mne_pkg::STEP_ON_STATUS;
      end
      mne_pkg::STEP_ON_STATUS: begin
        byte_next = {mne_pkg::StatusNoteOn, head.channel};
        step_next = mne_pkg::STEP_ON_PITCH;
      end
      mne_pkg::STEP_ON_PITCH: begin
        byte_next = {1'b0, head.pitch};
        step_next = mne_pkg::STEP_ON_VEL;
      end
      mne_pkg::STEP_ON_VEL: begin
        byte_next = {1'b0, head.velocity};
        step_next = mne_pkg::STEP_LEN_HI;
      end
      mne_pkg::STEP_LEN_HI: begin
        if (mne_pkg::vlq_long(head.length)) begin
          byte_next = mne_pkg::vlq_hi(head.length);
          step_next = mne_pkg::STEP_LEN_LO;
        end else begin
          byte_next = mne_pkg::vlq_lo(head.length);
          step_next = mne_pkg::STEP_OFF_STATUS;
        end
      end
      mne_pkg::STEP_LEN_LO: begin
        byte_next = mne_pkg::vlq_lo(head.length);
        step_next = mne_pkg::STEP_OFF_STATUS;
      end
      mne_pkg::STEP_OFF_STATUS: begin
        byte_next = {mne_pkg::StatusNoteOff, head.channel};
        step_next = mne_pkg::STEP_OFF_PITCH;
      end
      mne_pkg::STEP_OFF_PITCH: begin
        byte_next = {1'b0, head.pitch};
        step_next = mne_pkg::STEP_OFF_VEL;
      end
      mne_pkg::STEP_OFF_VEL: begin
        byte_next = {1'b0, head.velocity};
        last_next = 1'b1;
        step_next = mne_pkg::STEP_DLY_HI;
      end
      default: begin
        step_next = mne_pkg::STEP_DLY_HI;
      end
    endcase
  end

  // Step register advances only when a byte is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= mne_pkg::STEP_DLY_HI;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      last     <= last_next;
    end
  end

endmodule
